FILE: sv/fcce_pkg.sv
// ----------------------------------------------------------------------------
// fcce_pkg: shared types and constants for the cluster chain engine
// Table geometry, request and status codes, and the command/status bundles
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package fcce_pkg;

  localparam int TABLE_DEPTH        = 4096;
  localparam int ADDR_W             = $clog2(TABLE_DEPTH);
  localparam int CNT_W              = ADDR_W + 1;
  localparam int FIRST_DATA_CLUSTER = 2;

  localparam logic [12:0] ENTRIES_RESET = 13'd4096;
  localparam logic [31:0] EOC_RESET     = 32'h0FFF_FFFF;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_READ   = 3'd1,
    OP_COUNT  = 3'd2,
    OP_FIRST  = 3'd3,
    OP_APPEND = 3'd4,
    OP_TRIM   = 3'd5,
    OP_NTH    = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_SPACE    = 3'd1,
    ST_ENDED_EARLY = 3'd2,
    ST_RANGE       = 3'd3,
    ST_BROKEN      = 3'd4
  } status_t;

  typedef enum logic {
    CFG_ENTRIES = 1'b0,
    CFG_EOC     = 1'b1
  } cfg_idx_t;

  // table write selection
  typedef enum logic [2:0] {
    WR_NONE,
    WR_ENTRY,      // requested entry <= request value
    WR_TAIL_LINK,  // tail <= found free cluster
    WR_FREE_EOC,   // found cluster <= end of chain
    WR_PREV_EOC,   // cluster before tail <= end of chain
    WR_TAIL_FREE   // tail <= 0
  } wr_sel_t;

  typedef enum logic [2:0] {
    ANS_ZERO,
    ANS_RDATA,
    ANS_COUNT,
    ANS_FOUND,
    ANS_POS
  } ans_sel_t;

  typedef struct packed {
    logic     load;
    logic     rd_pos;
    logic     walk_adv;
    logic     nth_adv;
    logic     scan_init;
    logic     scan_run;
    wr_sel_t  wr;
    logic     finish;
    status_t  fin_status;
    ans_sel_t fin_ans;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic start_bad;
    logic chain_bad;
    logic offset_zero;
    logic pos_is_eoc;
    logic pos_in_range;
    logic rd_is_eoc;
    logic rd_link_bad;
    logic has_prev;
    logic scan_hit;
    logic scan_done;
  } stat_t;

endpackage

FILE: sv/fat_cluster_chain_engine_core.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine_core: FAT32 cluster chain engine
// Holds a 32-bit allocation table and serves one request at a time: entry
// write/read, free count, first free, append, trim last and nth link.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | beat contents
//  ----------+------------------------+---------------------------------------
//  request   | start / busy           | op, cluster, entry_value, link_offset
//  result    | done (one-cycle pulse) | status, answer
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  Write and out-of-range rejects finish in dispatch, read in a read-done state;
//  count free and first free read one table entry a cycle through the single
//  read port; walks read then check each link; append adds a scan and two writes.
//  Reset: synchronous; config returns to 4096 entries and end of chain
//  0x0FFFFFFF; the table itself is not cleared and holds junk until written.
//  Stalls: none on the result side; busy stays high from the accepted beat
//  until the cycle that carries done, where a new request may already enter.
//  cfg_ready is always high; write configuration only while busy is low.
//
module fat_cluster_chain_engine_core (
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op,
  input  logic [11:0] cluster,
  input  logic [31:0] entry_value,
  input  logic [12:0] link_offset,
  // result
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] answer,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  fcce_pkg::cmd_t  cmd;
  fcce_pkg::stat_t stat;

  // configuration is taken every cycle; the register file has no hazards
  assign cfg_ready = 1'b1;

  // sequencer: decode the request and step the datapath
  fcce_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // table memory, walk/scan registers and the result register
  fcce_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .op          (op),
    .cluster     (cluster),
    .entry_value (entry_value),
    .link_offset (link_offset),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .status      (status),
    .answer      (answer)
  );

endmodule

FILE: sv/fcce_dp.sv
// ----------------------------------------------------------------------------
// fcce_dp: cluster chain datapath
// Allocation table memory, request registers, walk and scan registers,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module fcce_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [2:0]          op,
  input  logic [11:0]         cluster,
  input  logic [31:0]         entry_value,
  input  logic [12:0]         link_offset,
  input  fcce_pkg::cmd_t      cmd,
  output fcce_pkg::stat_t     stat,
  output logic                done,
  output logic [2:0]          status,
  output logic [31:0]         answer
);

  localparam int AW = fcce_pkg::ADDR_W;
  localparam int CW = fcce_pkg::CNT_W;

  logic [31:0]          table_mem [fcce_pkg::TABLE_DEPTH];

  logic [12:0]          entries;
  logic [31:0]          eoc;
  fcce_pkg::op_t        req_op;
  logic [11:0]          req_cluster;
  logic [31:0]          req_value;
  logic [12:0]          offset;
  logic [31:0]          pos;
  logic [AW-1:0]        prev;
  logic                 has_prev;
  logic [CW-1:0]        steps;
  logic [CW-1:0]        scan_idx;
  logic                 pend;
  logic [AW-1:0]        pend_idx;
  logic [CW-1:0]        free_count;
  logic [AW-1:0]        found;
  logic [31:0]          rd_data;

  logic [CW-1:0]        limit;
  logic [31:0]          lim32;
  logic                 scan_issue;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [31:0]          wr_data;
  logic [31:0]          ans_next;

  function automatic logic in_rng(input logic [31:0] x, input logic [31:0] n);
    return (x >= 32'(fcce_pkg::FIRST_DATA_CLUSTER)) && (x < n);
  endfunction

  // saturate the entry count at the table depth
  always_comb begin
    if (32'(entries) > 32'(fcce_pkg::TABLE_DEPTH)) begin
      limit = CW'(fcce_pkg::TABLE_DEPTH);
    end else begin
      limit = CW'(entries);
    end
    lim32 = 32'(limit);
  end

  assign scan_issue = scan_idx < limit;
  assign rd_en      = cmd.rd_pos || (cmd.scan_run && scan_issue);
  assign rd_addr    = cmd.rd_pos ? pos[AW-1:0] : scan_idx[AW-1:0];

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = pos[AW-1:0];
    wr_data = 32'd0;
    case (cmd.wr)
      fcce_pkg::WR_ENTRY: begin
        wr_addr = AW'(req_cluster);
        wr_data = req_value;
      end
      fcce_pkg::WR_TAIL_LINK: begin
        wr_data = 32'(found);
      end
      fcce_pkg::WR_FREE_EOC: begin
        wr_addr = found;
        wr_data = eoc;
      end
      fcce_pkg::WR_PREV_EOC: begin
        wr_addr = prev;
        wr_data = eoc;
      end
      fcce_pkg::WR_TAIL_FREE: begin
        wr_data = 32'd0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  always_comb begin
    stat.op           = req_op;
    stat.start_bad    = 32'(req_cluster) >= lim32;
    stat.chain_bad    = !in_rng(32'(req_cluster), lim32);
    stat.offset_zero  = offset == 13'd0;
    stat.pos_is_eoc   = pos == eoc;
    stat.pos_in_range = in_rng(pos, lim32);
    stat.rd_is_eoc    = rd_data == eoc;
    stat.rd_link_bad  = !in_rng(rd_data, lim32) || (steps >= limit);
    stat.has_prev     = has_prev;
    stat.scan_hit     = pend && (rd_data == 32'd0);
    stat.scan_done    = !pend && !scan_issue;
  end

  always_comb begin
    case (cmd.fin_ans)
      fcce_pkg::ANS_RDATA: ans_next = rd_data;
      fcce_pkg::ANS_COUNT: ans_next = 32'(free_count);
      fcce_pkg::ANS_FOUND: ans_next = 32'(found);
      fcce_pkg::ANS_POS:   ans_next = pos;
      default:             ans_next = 32'd0;
    endcase
  end

  // configuration and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= fcce_pkg::ENTRIES_RESET;
      eoc     <= fcce_pkg::EOC_RESET;
      done    <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cfg_valid) begin
        unique case (fcce_pkg::cfg_idx_t'(cfg_index))
          fcce_pkg::CFG_ENTRIES: entries <= cfg_data[12:0];
          fcce_pkg::CFG_EOC:     eoc     <= cfg_data;
          default:               ;
        endcase
      end
    end
  end

  // request, walk and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op      <= fcce_pkg::op_t'(op);
      req_cluster <= cluster;
      req_value   <= entry_value;
      offset      <= link_offset;
      pos         <= 32'(cluster);
      has_prev    <= 1'b0;
      steps       <= '0;
    end
    if (cmd.walk_adv) begin
      prev     <= pos[AW-1:0];
      has_prev <= 1'b1;
      pos      <= rd_data;
      steps    <= steps + CW'(1);
    end
    if (cmd.nth_adv) begin
      pos    <= rd_data;
      offset <= offset - 13'd1;
    end
    if (cmd.scan_init) begin
      scan_idx   <= CW'(fcce_pkg::FIRST_DATA_CLUSTER);
      pend       <= 1'b0;
      free_count <= '0;
    end else if (cmd.scan_run) begin
      pend     <= scan_issue;
      pend_idx <= scan_idx[AW-1:0];
      if (scan_issue) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (pend && (rd_data == 32'd0)) begin
        free_count <= free_count + CW'(1);
        found      <= pend_idx;
      end
    end
    if (cmd.finish) begin
      status <= cmd.fin_status;
      answer <= ans_next;
    end
  end

endmodule

FILE: sv/fcce_ctrl.sv
// ----------------------------------------------------------------------------
// fcce_ctrl: cluster chain request sequencer
// Decodes a request and steps the datapath through reads, scans, chain walks
// and table updates.
// ----------------------------------------------------------------------------
module fcce_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  fcce_pkg::stat_t stat,
  output fcce_pkg::cmd_t  cmd,
  output logic            busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ_DONE,
    S_WALK_RD,
    S_WALK_EV,
    S_SCAN,
    S_FOUND,
    S_APPEND_EOC,
    S_TRIM_FREE,
    S_NTH,
    S_NTH_EV
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.op)
          fcce_pkg::OP_WRITE: begin
            cmd.finish = 1'b1;
            if (stat.start_bad) begin
              cmd.fin_status = fcce_pkg::ST_RANGE;
            end else begin
              cmd.wr = fcce_pkg::WR_ENTRY;
            end
            state_next = S_IDLE;
          end
          fcce_pkg::OP_READ: begin
            if (stat.start_bad) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = fcce_pkg::ST_RANGE;
              state_next     = S_IDLE;
            end else begin
              cmd.rd_pos = 1'b1;
              state_next = S_READ_DONE;
            end
          end
          fcce_pkg::OP_COUNT, fcce_pkg::OP_FIRST: begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
          fcce_pkg::OP_APPEND, fcce_pkg::OP_TRIM: begin
            if (stat.chain_bad) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = fcce_pkg::ST_RANGE;
              state_next     = S_IDLE;
            end else begin
              cmd.rd_pos = 1'b1;
              state_next = S_WALK_EV;
            end
          end
          fcce_pkg::OP_NTH: begin
            if (!stat.offset_zero && stat.chain_bad) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = fcce_pkg::ST_RANGE;
              state_next     = S_IDLE;
            end else begin
              state_next = S_NTH;
            end
          end
          default: begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_READ_DONE: begin
        cmd.finish  = 1'b1;
        cmd.fin_ans = fcce_pkg::ANS_RDATA;
        state_next  = S_IDLE;
      end
      S_WALK_RD: begin
        cmd.rd_pos = 1'b1;
        state_next = S_WALK_EV;
      end
      S_WALK_EV: begin
        if (stat.rd_is_eoc) begin
          if (stat.op == fcce_pkg::OP_APPEND) begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end else if (stat.has_prev) begin
            cmd.wr     = fcce_pkg::WR_PREV_EOC;
            state_next = S_TRIM_FREE;
          end else begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end else if (stat.rd_link_bad) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = fcce_pkg::ST_BROKEN;
          state_next     = S_IDLE;
        end else begin
          cmd.walk_adv = 1'b1;
          state_next   = S_WALK_RD;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_hit && (stat.op != fcce_pkg::OP_COUNT)) begin
          state_next = S_FOUND;
        end else if (stat.scan_done) begin
          cmd.finish = 1'b1;
          if (stat.op == fcce_pkg::OP_COUNT) begin
            cmd.fin_ans = fcce_pkg::ANS_COUNT;
          end else begin
            cmd.fin_status = fcce_pkg::ST_NO_SPACE;
          end
          state_next = S_IDLE;
        end
      end
      S_FOUND: begin
        if (stat.op == fcce_pkg::OP_FIRST) begin
          cmd.finish  = 1'b1;
          cmd.fin_ans = fcce_pkg::ANS_FOUND;
          state_next  = S_IDLE;
        end else begin
          cmd.wr     = fcce_pkg::WR_TAIL_LINK;
          state_next = S_APPEND_EOC;
        end
      end
      S_APPEND_EOC: begin
        cmd.wr      = fcce_pkg::WR_FREE_EOC;
        cmd.finish  = 1'b1;
        cmd.fin_ans = fcce_pkg::ANS_FOUND;
        state_next  = S_IDLE;
      end
      S_TRIM_FREE: begin
        cmd.wr      = fcce_pkg::WR_TAIL_FREE;
        cmd.finish  = 1'b1;
        cmd.fin_ans = fcce_pkg::ANS_POS;
        state_next  = S_IDLE;
      end
      S_NTH: begin
        if (stat.offset_zero || stat.pos_is_eoc) begin
          cmd.finish = 1'b1;
          if (stat.offset_zero) begin
            cmd.fin_ans = fcce_pkg::ANS_POS;
          end else begin
            cmd.fin_status = fcce_pkg::ST_ENDED_EARLY;
          end
          state_next = S_IDLE;
        end else if (!stat.pos_in_range) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = fcce_pkg::ST_BROKEN;
          state_next     = S_IDLE;
        end else begin
          cmd.rd_pos = 1'b1;
          state_next = S_NTH_EV;
        end
      end
      S_NTH_EV: begin
        cmd.nth_adv = 1'b1;
        state_next  = S_NTH;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/fcce_checker.sv
// ----------------------------------------------------------------------------
// fcce_checker: port-level checks for the cluster chain engine
// Watches the request/result handshake and result encoding over time.
// ----------------------------------------------------------------------------
module fcce_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic [31:0] answer
);

  // an accepted request holds the engine busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("engine not busy after accepting a request");

  // the result beat lands in the cycle the engine frees up
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_release_with_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("engine released without a result");

  a_error_answer_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != fcce_pkg::ST_OK)) |-> (answer == 32'd0))
    else $error("failed request carries a nonzero answer");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == fcce_pkg::ST_OK || status == fcce_pkg::ST_NO_SPACE ||
              status == fcce_pkg::ST_ENDED_EARLY || status == fcce_pkg::ST_RANGE ||
              status == fcce_pkg::ST_BROKEN))
    else $error("result status code out of range");

endmodule

bind fat_cluster_chain_engine_core fcce_checker u_fcce_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .status (status),
  .answer (answer)
);
